// File: rtl/smrh_pkg.sv
`timescale 1ns / 1ps
package smrh_pkg;

    // fixed field widths
    localparam int TW    = 31;          // layer thickness
    localparam int LW    = 10;          // layer count
    localparam int HW    = TW + LW;     // slab height
    localparam int KW    = 8;           // bounce count
    localparam int MKW   = KW + 1;      // height multiple
    localparam int ZW    = 52;          // signed z and difference path
    localparam int MW    = ZW - 1;      // magnitudes
    localparam int ANG_W = 23;
    localparam int ST_W  = 2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NOHIT = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

    // register indexes
    localparam logic CFG_THICK = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic [TW-1:0] THICK_RST = 31'd65536;
    localparam logic [LW-1:0] COUNT_RST = 10'd10;

    // angle unit
    localparam int NW    = 30;          // normalized magnitude width
    localparam int SW    = 2 * NW + 1;  // sum of squares
    localparam int RW    = SW + 1;      // root accumulator
    localparam int SQ_N  = 31;          // root bits
    localparam int CD_N  = 28;          // rotation steps
    localparam int CXW   = 34;
    localparam int CZW   = 33;
    localparam int ANG_LAT = 6 + SQ_N + CD_N + 1;

    localparam logic signed [CZW-1:0] DEG90_Q24 = 33'sd1509949440;
    localparam logic [ANG_W-1:0] ANGLE_MAX = 23'd5898240;

    // atan(2^-i) in 2^-24 degree
    localparam logic [30:0] ATAN_Q24 [CD_N] = '{
        31'd754974720, 31'd445687602, 31'd235489089, 31'd119537938, 31'd60000934,
        31'd30029717, 31'd15018523, 31'd7509720, 31'd3754917, 31'd1877466,
        31'd938734, 31'd469367, 31'd234684, 31'd117342, 31'd58671, 31'd29335,
        31'd14668, 31'd7334, 31'd3667, 31'd1833, 31'd917, 31'd458, 31'd229,
        31'd115, 31'd57, 31'd29, 31'd14, 31'd7
    };

    typedef logic [MW-1:0] t_mag;

    // arithmetic right shift rounding toward zero
    function automatic logic signed [CXW-1:0] shr_tz(input logic signed [CXW-1:0] v,
                                                     input int s);
        logic [CXW-1:0] bias;
        bias = (CXW'(1) << s) - CXW'(1);
        if (!v[CXW-1]) bias = '0;
        return (v + $signed(bias)) >>> s;
    endfunction

endpackage

// File: rtl/smrh_hit_axis.sv
`timescale 1ns / 1ps
module smrh_hit_axis import smrh_pkg::*; #(
    parameter int CW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_s,
    input  logic                 i_dneg,
    input  t_mag                 i_num,
    input  t_mag                 i_dmag,
    input  t_mag                 i_den,
    output logic signed [CW-1:0] o_hit,
    output logic                 o_sat
);
    localparam int QB  = CW + 1;
    localparam int PW  = 2 * MW;
    localparam int HF  = (MW + 1) / 2;
    localparam int LF  = MW - HF;
    localparam int PAD = ANG_LAT - QB - 4;
    localparam int VW  = CW + 3;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMAX = $signed(VW'(CMAX));
    localparam logic signed [VW-1:0] VMIN = -VMAX - VW'(1);

    typedef struct packed {
        logic [CW-1:0] s;
        logic          dneg;
        t_mag          den;
    } t_ctl;

    // partial products
    logic [2*HF-1:0]  r1_pll;
    logic [HF+LF-1:0] r1_plh, r1_phl;
    logic [2*LF-1:0]  r1_phh;
    t_ctl             r1_ctl;
    logic [PW-1:0]    r2_n;
    t_ctl             r2_ctl;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pll <= (2*HF)'(i_num[HF-1:0]) * (2*HF)'(i_dmag[HF-1:0]);
            r1_plh <= (HF+LF)'(i_num[HF-1:0]) * (HF+LF)'(i_dmag[MW-1:HF]);
            r1_phl <= (HF+LF)'(i_num[MW-1:HF]) * (HF+LF)'(i_dmag[HF-1:0]);
            r1_phh <= (2*LF)'(i_num[MW-1:HF]) * (2*LF)'(i_dmag[MW-1:HF]);
            r1_ctl <= '{s: i_s, dneg: i_dneg, den: i_den};
            r2_n   <= PW'(r1_pll) + (PW'(r1_plh) << HF) + (PW'(r1_phl) << HF)
                      + (PW'(r1_phh) << (2 * HF));
            r2_ctl <= r1_ctl;
        end
    end

    // quotient pipeline, one bit per stage
    t_mag          r_rem [QB+1];
    logic [QB-1:0] r_low [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    t_ctl          r_ctl [QB+1];
    logic          r_big [QB+1];
    t_mag          n_rem [QB];
    logic [QB-1:0] n_low [QB];
    logic [QB-1:0] n_q   [QB];
    logic [PW-QB-1:0] w_hi;

    assign w_hi = r2_n[PW-1:QB];

    always_comb begin
        logic [MW:0] t;
        logic        ge;
        for (int j = 0; j < QB; j++) begin
            t = {r_rem[j], r_low[j][QB-1]};
            ge = t >= {1'b0, r_ctl[j].den};
            n_rem[j] = ge ? MW'(t - {1'b0, r_ctl[j].den}) : t[MW-1:0];
            n_low[j] = r_low[j] << 1;
            n_q[j]   = {r_q[j][QB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_hi[MW-1:0];
            r_low[0] <= r2_n[QB-1:0];
            r_q[0]   <= '0;
            r_ctl[0] <= r2_ctl;
            r_big[0] <= w_hi >= (PW-QB)'(r2_ctl.den);
            for (int j = 0; j < QB; j++) begin
                r_rem[j+1] <= n_rem[j];
                r_low[j+1] <= n_low[j];
                r_q[j+1]   <= n_q[j];
                r_ctl[j+1] <= r_ctl[j];
                r_big[j+1] <= r_big[j];
            end
        end
    end

    // offset from start, then clamp
    logic signed [VW-1:0] w_sv, w_qv, w_v;
    logic signed [CW-1:0] n_hit;
    logic                 n_sat;

    assign w_sv = VW'($signed(r_ctl[QB].s));
    assign w_qv = $signed(VW'(r_q[QB]));
    assign w_v  = r_ctl[QB].dneg ? w_sv - w_qv : w_sv + w_qv;

    always_comb begin
        n_sat = 1'b1;
        priority if (r_big[QB]) begin
            n_hit = r_ctl[QB].dneg ? CW'(VMIN) : CW'(VMAX);
        end else if (w_v > VMAX) begin
            n_hit = CW'(VMAX);
        end else if (w_v < VMIN) begin
            n_hit = CW'(VMIN);
        end else begin
            n_hit = CW'(w_v);
            n_sat = 1'b0;
        end
    end

    // delay to match the angle unit
    logic signed [CW-1:0] r_phit [PAD+1];
    logic                 r_psat [PAD+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phit[0] <= n_hit;
            r_psat[0] <= n_sat;
            for (int j = 0; j < PAD; j++) begin
                r_phit[j+1] <= r_phit[j];
                r_psat[j+1] <= r_psat[j];
            end
        end
    end

    assign o_hit = r_phit[PAD];
    assign o_sat = r_psat[PAD];

endmodule

// File: rtl/smrh_angle.sv
`timescale 1ns / 1ps
module smrh_angle import smrh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_mag             i_ax,
    input  t_mag             i_ay,
    input  t_mag             i_az,
    output logic [ANG_W-1:0] o_angle
);
    localparam int GN  = (MW + 7) / 8;
    localparam int PB  = $clog2(GN * 8);
    localparam int TOP = NW - 1;

    // largest magnitude
    t_mag r_ax1, r_ay1, r_az1, r_m1, n_m1;

    always_comb begin
        n_m1 = (i_ax > i_ay) ? i_ax : i_ay;
        if (i_az > n_m1) n_m1 = i_az;
    end

    // leading one per byte group
    logic [GN*8-1:0] w_mpad;
    logic [GN-1:0]   n_gnz, r_gnz2;
    logic [2:0]      n_gpos [GN];
    logic [2:0]      r_gpos2 [GN];
    t_mag            r_ax2, r_ay2, r_az2;

    assign w_mpad = (GN*8)'(r_m1);

    always_comb begin
        for (int g = 0; g < GN; g++) begin
            n_gnz[g]  = |w_mpad[g*8 +: 8];
            n_gpos[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (w_mpad[g*8+b]) n_gpos[g] = 3'(b);
            end
        end
    end

    // top group picks the position
    logic [PB-1:0] n_p3, r_p3;
    t_mag          r_ax3, r_ay3, r_az3;

    always_comb begin
        n_p3 = '0;
        for (int g = 0; g < GN; g++) begin
            if (r_gnz2[g]) n_p3 = PB'(g * 8) + PB'(r_gpos2[g]);
        end
    end

    // common shift to put the leading one at bit TOP
    logic [PB-1:0] n_sh;
    logic [NW-1:0] n_ax4, n_ay4, n_az4, r_ax4, r_ay4, r_az4;

    always_comb begin
        if (r_p3 >= PB'(TOP)) begin
            n_sh  = r_p3 - PB'(TOP);
            n_ax4 = NW'(r_ax3 >> n_sh);
            n_ay4 = NW'(r_ay3 >> n_sh);
            n_az4 = NW'(r_az3 >> n_sh);
        end else begin
            n_sh  = PB'(TOP) - r_p3;
            n_ax4 = NW'(r_ax3 << n_sh);
            n_ay4 = NW'(r_ay3 << n_sh);
            n_az4 = NW'(r_az3 << n_sh);
        end
    end

    // squares, then their sum
    logic [2*NW-1:0] r_sx5, r_sy5;
    logic [NW-1:0]   r_az5;

    logic [SW-1:0] r_sn  [SQ_N+1];
    logic [RW-1:0] r_sr  [SQ_N+1];
    logic [NW-1:0] r_saz [SQ_N+1];
    logic [SW-1:0] n_sn  [SQ_N];
    logic [RW-1:0] n_sr  [SQ_N];

    // integer root, one bit per stage
    always_comb begin
        logic [RW-1:0] bitv;
        logic [RW-1:0] t;
        for (int i = 0; i < SQ_N; i++) begin
            bitv = RW'(1) << (2 * (SQ_N - 1 - i));
            t    = r_sr[i] + bitv;
            if ({1'b0, r_sn[i]} >= t) begin
                n_sn[i] = r_sn[i] - t[SW-1:0];
                n_sr[i] = (r_sr[i] >> 1) + bitv;
            end else begin
                n_sn[i] = r_sn[i];
                n_sr[i] = r_sr[i] >> 1;
            end
        end
    end

    // vectoring rotations
    logic signed [CXW-1:0] c_x [CD_N], c_y [CD_N], n_cx [CD_N], n_cy [CD_N];
    logic signed [CZW-1:0] c_z [CD_N], n_cz [CD_N];
    logic                  c_zr [CD_N];
    logic signed [CXW-1:0] r_cx [CD_N], r_cy [CD_N];
    logic signed [CZW-1:0] r_cz [CD_N];
    logic                  r_czr [CD_N];

    always_comb begin
        logic signed [CXW-1:0] xs, ys;
        logic signed [CZW-1:0] a;
        c_x[0]  = $signed(CXW'(r_saz[SQ_N]));
        c_y[0]  = $signed(CXW'(r_sr[SQ_N]));
        c_z[0]  = '0;
        c_zr[0] = r_sr[SQ_N] == '0;
        for (int i = 1; i < CD_N; i++) begin
            c_x[i]  = r_cx[i-1];
            c_y[i]  = r_cy[i-1];
            c_z[i]  = r_cz[i-1];
            c_zr[i] = r_czr[i-1];
        end
        for (int i = 0; i < CD_N; i++) begin
            xs = shr_tz(c_x[i], i);
            ys = shr_tz(c_y[i], i);
            a  = $signed(CZW'(ATAN_Q24[i]));
            if (c_y[i] > 0) begin
                n_cx[i] = c_x[i] + ys;
                n_cy[i] = c_y[i] - xs;
                n_cz[i] = c_z[i] + a;
            end else begin
                n_cx[i] = c_x[i] - ys;
                n_cy[i] = c_y[i] + xs;
                n_cz[i] = c_z[i] - a;
            end
        end
    end

    // clamp to a quarter turn and round to Q7.16
    logic signed [CZW-1:0] w_zc, w_zr;
    logic [ANG_W-1:0]      r_ang;

    always_comb begin
        w_zc = r_cz[CD_N-1];
        if (w_zc < 0) w_zc = '0;
        if (w_zc > DEG90_Q24) w_zc = DEG90_Q24;
        w_zr = w_zc + CZW'(128);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax1 <= i_ax; r_ay1 <= i_ay; r_az1 <= i_az; r_m1 <= n_m1;
            r_gnz2 <= n_gnz; r_gpos2 <= n_gpos;
            r_ax2 <= r_ax1; r_ay2 <= r_ay1; r_az2 <= r_az1;
            r_p3 <= n_p3;
            r_ax3 <= r_ax2; r_ay3 <= r_ay2; r_az3 <= r_az2;
            r_ax4 <= n_ax4; r_ay4 <= n_ay4; r_az4 <= n_az4;
            r_sx5 <= (2*NW)'(r_ax4) * (2*NW)'(r_ax4);
            r_sy5 <= (2*NW)'(r_ay4) * (2*NW)'(r_ay4);
            r_az5 <= r_az4;
            r_sn[0]  <= SW'(r_sx5) + SW'(r_sy5);
            r_sr[0]  <= '0;
            r_saz[0] <= r_az5;
            for (int i = 0; i < SQ_N; i++) begin
                r_sn[i+1]  <= n_sn[i];
                r_sr[i+1]  <= n_sr[i];
                r_saz[i+1] <= r_saz[i];
            end
            for (int i = 0; i < CD_N; i++) begin
                r_cx[i]  <= n_cx[i];
                r_cy[i]  <= n_cy[i];
                r_cz[i]  <= n_cz[i];
                r_czr[i] <= c_zr[i];
            end
            r_ang <= r_czr[CD_N-1] ? '0 : w_zr[8 +: ANG_W];
        end
    end

    assign o_angle = r_ang;

endmodule

// File: rtl/slab_mirror_reflection_hit_core.sv
`timescale 1ns / 1ps
// channel  | dir | handshake                 | payload
// cfg      | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// s (rays) | in  | i_s_tvalid / o_s_tready   | i_s_tdata, i_s_tuser
// m (hits) | out | o_m_tvalid / i_m_tready   | o_m_tdata, o_m_tuser
//
// one ray per cycle; the depth is set by the 31-step root and the
// 28-step rotation chain of the angle unit (the divider is padded to match)
// all stages advance together; a stalled output holds the whole pipeline
// reset (synchronous, active low) clears valid bits and loads the default
// layer thickness and count; payload registers are not reset
module slab_mirror_reflection_hit_core import smrh_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int MAX_BOUNCES = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [TW-1:0]        i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, bounces_left
    input  logic [((6*COORD_WIDTH+KW+7)/8)*8-1:0] i_s_tdata,
    // face_is_top
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // hit_x, hit_y, hit_z, incidence_deg
    output logic [((3*COORD_WIDTH+ANG_W+7)/8)*8-1:0] o_m_tdata,
    // status
    output logic [ST_W-1:0]      o_m_tuser
);
    localparam int CW  = COORD_WIDTH;
    localparam int ODW = ((3*CW+ANG_W+7)/8)*8;
    localparam int FRONT = 5;
    localparam int TOT = FRONT + ANG_LAT + 1;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct packed {
        logic          fail;
        logic [CW-1:0] hz;
        logic          hz_sat;
    } t_side;

    logic w_en;
    logic r_vld [TOT];

    assign w_en       = !r_vld[TOT-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic [TW-1:0] r_thick;
    logic [LW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thick <= THICK_RST;
            r_count <= COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THICK: r_thick <= i_cfg_data;
                CFG_COUNT: r_count <= i_cfg_data[LW-1:0];
                default:   r_thick <= r_thick;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOT; i++) r_vld[i] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_s_tvalid;
            for (int i = 1; i < TOT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // stage 1: unpack, clamp bounces, slab height
    logic signed [CW-1:0] r1_sx, r1_sy, r1_sz, r1_ex, r1_ey, r1_ez;
    logic [KW-1:0]        r1_k, n1_k;
    logic                 r1_top;
    logic [HW-1:0]        r1_h;

    assign n1_k = (int'(i_s_tdata[6*CW +: KW]) > MAX_BOUNCES) ? KW'(MAX_BOUNCES)
                                                              : i_s_tdata[6*CW +: KW];

    // stage 2: height multiple
    logic [MKW-1:0]       n2_m;
    logic [HW+MKW-1:0]    r2_kh;
    logic signed [CW-1:0] r2_sx, r2_sy, r2_sz, r2_ex, r2_ey, r2_ez;
    logic                 r2_top, r2_odd;
    logic [HW-1:0]        r2_h;

    always_comb begin
        priority if (!r1_k[0]) n2_m = MKW'(r1_k);
        else if (r1_top)       n2_m = MKW'(r1_k) + MKW'(1);
        else                   n2_m = MKW'(r1_k) - MKW'(1);
    end

    // stage 3: moved end z
    logic signed [ZW-1:0] w3_ez, w3_kh, w3_t, n3_ez2, r3_ez2, r3_plane;
    logic signed [CW-1:0] r3_sx, r3_sy, r3_sz, r3_ex, r3_ey;

    assign w3_ez = ZW'(r2_ez);
    assign w3_kh = $signed(ZW'(r2_kh));

    always_comb begin
        w3_t = r2_top ? w3_kh - w3_ez : w3_kh + w3_ez;
        priority if (!r2_odd) n3_ez2 = r2_top ? w3_ez + w3_kh : w3_ez - w3_kh;
        else if (r2_top)      n3_ez2 = w3_t[ZW-1] ? -w3_t : w3_t;
        else                  n3_ez2 = w3_t[ZW-1] ? w3_t : -w3_t;
    end

    // stage 4: direction and distance to the face
    logic signed [ZW-1:0] r4_dx, r4_dy, r4_dz, r4_num, r4_plane;
    logic signed [CW-1:0] r4_sx, r4_sy;

    // stage 5: magnitudes, no-hit test, face height clamp
    t_mag                 r5_ax, r5_ay, r5_az, r5_num;
    logic                 r5_dxn, r5_dyn;
    logic signed [CW-1:0] r5_sx, r5_sy;
    t_side                r5_side;
    t_side                n5_side;

    function automatic t_mag mag_of(input logic signed [ZW-1:0] v);
        return v[ZW-1] ? MW'(-v) : MW'(v);
    endfunction

    always_comb begin
        n5_side.fail = (r4_dz == '0) || (r4_num == '0) || (r4_num[ZW-1] != r4_dz[ZW-1]);
        n5_side.hz_sat = (r4_plane >>> (CW - 1)) != '0;
        n5_side.hz = n5_side.hz_sat ? CMAX : r4_plane[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sx  <= i_s_tdata[0*CW +: CW];
            r1_sy  <= i_s_tdata[1*CW +: CW];
            r1_sz  <= i_s_tdata[2*CW +: CW];
            r1_ex  <= i_s_tdata[3*CW +: CW];
            r1_ey  <= i_s_tdata[4*CW +: CW];
            r1_ez  <= i_s_tdata[5*CW +: CW];
            r1_k   <= n1_k;
            r1_top <= i_s_tuser;
            r1_h   <= HW'(r_thick) * HW'(r_count);

            r2_kh  <= (HW+MKW)'(r1_h) * (HW+MKW)'(n2_m);
            r2_sx  <= r1_sx; r2_sy <= r1_sy; r2_sz <= r1_sz;
            r2_ex  <= r1_ex; r2_ey <= r1_ey; r2_ez <= r1_ez;
            r2_top <= r1_top;
            r2_odd <= r1_k[0];
            r2_h   <= r1_h;

            r3_ez2   <= n3_ez2;
            r3_plane <= r2_top ? $signed(ZW'(r2_h)) : '0;
            r3_sx <= r2_sx; r3_sy <= r2_sy; r3_sz <= r2_sz;
            r3_ex <= r2_ex; r3_ey <= r2_ey;

            r4_dx    <= ZW'(r3_ex) - ZW'(r3_sx);
            r4_dy    <= ZW'(r3_ey) - ZW'(r3_sy);
            r4_dz    <= r3_ez2 - ZW'(r3_sz);
            r4_num   <= r3_plane - ZW'(r3_sz);
            r4_plane <= r3_plane;
            r4_sx    <= r3_sx; r4_sy <= r3_sy;

            r5_ax   <= mag_of(r4_dx);
            r5_ay   <= mag_of(r4_dy);
            r5_az   <= mag_of(r4_dz);
            r5_num  <= mag_of(r4_num);
            r5_dxn  <= r4_dx[ZW-1];
            r5_dyn  <= r4_dy[ZW-1];
            r5_sx   <= r4_sx; r5_sy <= r4_sy;
            r5_side <= n5_side;
        end
    end

    // per-axis hit and the angle unit
    logic signed [CW-1:0] w_hx, w_hy;
    logic                 w_sx, w_sy;
    logic [ANG_W-1:0]     w_ang;

    smrh_hit_axis #(.CW(CW)) u_hit_x (
        .i_clk (i_clk), .i_en (w_en), .i_s (r5_sx), .i_dneg (r5_dxn),
        .i_num (r5_num), .i_dmag (r5_ax), .i_den (r5_az),
        .o_hit (w_hx), .o_sat (w_sx)
    );

    smrh_hit_axis #(.CW(CW)) u_hit_y (
        .i_clk (i_clk), .i_en (w_en), .i_s (r5_sy), .i_dneg (r5_dyn),
        .i_num (r5_num), .i_dmag (r5_ay), .i_den (r5_az),
        .o_hit (w_hy), .o_sat (w_sy)
    );

    smrh_angle u_angle (
        .i_clk (i_clk), .i_en (w_en),
        .i_ax (r5_ax), .i_ay (r5_ay), .i_az (r5_az),
        .o_angle (w_ang)
    );

    // side information delayed alongside the units
    t_side r_side [ANG_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r5_side;
            for (int i = 1; i < ANG_LAT; i++) r_side[i] <= r_side[i-1];
        end
    end

    // output register
    logic [CW-1:0]    r_hx, r_hy, r_hz;
    logic [ANG_W-1:0] r_ang;
    logic [ST_W-1:0]  r_st;
    t_side            w_sd;

    assign w_sd = r_side[ANG_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_sd.fail) begin
                r_hx  <= '0;
                r_hy  <= '0;
                r_hz  <= '0;
                r_ang <= '0;
                r_st  <= ST_NOHIT;
            end else begin
                r_hx  <= w_hx;
                r_hy  <= w_hy;
                r_hz  <= w_sd.hz;
                r_ang <= w_ang;
                r_st  <= (w_sx || w_sy || w_sd.hz_sat) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_m_tvalid = r_vld[TOT-1];
    assign o_m_tdata  = ODW'({r_ang, r_hz, r_hy, r_hx});
    assign o_m_tuser  = r_st;

`ifndef SYNTHESIS
    // a ray without a forward hit carries an all-zero payload
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_NOHIT |-> o_m_tdata == '0)
        else $error("no-hit result with nonzero payload");

    // the angle never leaves the quarter turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_ang <= ANGLE_MAX)
        else $error("incidence angle out of range");

    // an accepted item enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted item lost at the first stage");

    // status never takes the unused code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser == ST_OK || o_m_tuser == ST_NOHIT
                       || o_m_tuser == ST_SAT)
        else $error("unused status code");
`endif

endmodule
